// ===== hdl/ctgl_pkg.sv =====
// ----------------------------------------------------------------------------
// ctgl_pkg: shared types and constants
// Modes, datapath operation codes, hash constants and the sparse-lookup
// step table used by the controller and the datapath.
// ----------------------------------------------------------------------------
package ctgl_pkg;

  // item modes
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_RANGE  = 2'd1;
  localparam logic [1:0] MODE_DISP   = 2'd2;
  localparam logic [1:0] MODE_VALUE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SEED   = 3'd0;
  localparam logic [2:0] REG_BUCKET = 3'd1;
  localparam logic [2:0] REG_SLOT   = 3'd2;
  localparam logic [2:0] REG_RANGES = 3'd3;

  // datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_RREAD = 4'd1;  // read range entry
  localparam logic [3:0] OP_K1    = 4'd2;  // key * C1
  localparam logic [3:0] OP_K2    = 4'd3;  // rotl15 * C2
  localparam logic [3:0] OP_ACC   = 4'd4;  // fold into accumulator
  localparam logic [3:0] OP_M1    = 4'd5;  // finalizer multiply 1
  localparam logic [3:0] OP_M2    = 4'd6;  // finalizer multiply 2
  localparam logic [3:0] OP_MH    = 4'd7;  // final xor, multiply-high
  localparam logic [3:0] OP_DREAD = 4'd8;  // read displacement
  localparam logic [3:0] OP_VREAD = 4'd9;  // read sparse value

  // result selection
  localparam logic [1:0] RES_NONE   = 2'd0;
  localparam logic [1:0] RES_MISS   = 2'd1;
  localparam logic [1:0] RES_DENSE  = 2'd2;
  localparam logic [1:0] RES_SPARSE = 2'd3;

  localparam logic [31:0] HC1 = 32'hcc9e2d51;
  localparam logic [31:0] HC2 = 32'h1b873593;
  localparam logic [31:0] HC3 = 32'he6546b64;
  localparam logic [31:0] HC4 = 32'h85ebca6b;
  localparam logic [31:0] HC5 = 32'hc2b2ae35;

  localparam logic [4:0] SEQ_LAST = 5'd17;

  typedef struct packed {
    logic [3:0] op;
    logic       key_disp;  // key is displacement word
    logic       acc_seed;  // accumulator is hash seed
    logic       slot_sel;  // multiply-high by slot count
  } seq_t;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
    logic       key_disp;
    logic       acc_seed;
    logic       slot_sel;
    logic [1:0] res_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       lookup;
    logic       hit;
    logic       sparse;
    logic [4:0] ranges;
  } stat_t;

  // sparse lookup step table
  function automatic seq_t seq_op(input logic [4:0] step);
    seq_t s;
    s = '{op: OP_NONE, key_disp: 1'b0, acc_seed: 1'b1, slot_sel: 1'b0};
    case (step)
      5'd0:  s.op = OP_K1;
      5'd1:  s.op = OP_K2;
      5'd2:  s.op = OP_ACC;
      5'd3:  s.op = OP_M1;
      5'd4:  s.op = OP_M2;
      5'd5:  s.op = OP_MH;
      5'd6:  s.op = OP_DREAD;
      5'd7:  begin s.op = OP_K1; s.key_disp = 1'b1; end
      5'd8:  s.op = OP_K2;
      5'd9:  s.op = OP_ACC;
      5'd10: s.op = OP_K1;
      5'd11: s.op = OP_K2;
      5'd12: begin s.op = OP_ACC; s.acc_seed = 1'b0; end
      5'd13: s.op = OP_M1;
      5'd14: s.op = OP_M2;
      5'd15: begin s.op = OP_MH; s.slot_sel = 1'b1; end
      5'd16: s.op = OP_VREAD;
      default: s.op = OP_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/ctgl_ram.sv =====
// ----------------------------------------------------------------------------
// ctgl_ram: generic single-port-write RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module ctgl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ctgl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctgl_ctrl: lookup controller
// Sequences the range scan and the sparse hash steps, owns the handshakes.
// ----------------------------------------------------------------------------
module ctgl_ctrl #(
  parameter int MAX_RANGES = 16,
  parameter int RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ctgl_pkg::stat_t  stat,
  output ctgl_pkg::cmd_t   cmd,
  output logic [RAW-1:0]   range_idx
);
  import ctgl_pkg::*;

  localparam int IW = $clog2(MAX_RANGES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RREAD = 3'd1;
  localparam logic [2:0] S_RCHK  = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [4:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   limit;
  logic          accept;
  seq_t          sq;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign range_idx = idx_r[RAW-1:0];
  assign sq        = seq_op(step_r);

  // scan limit clamps to the table depth
  always_comb begin
    limit = {27'd0, stat.ranges};
    if (limit > 32'(MAX_RANGES)) begin
      limit = 32'(MAX_RANGES);
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '{load: accept, op: OP_NONE, key_disp: 1'b0, acc_seed: 1'b1,
            slot_sel: 1'b0, res_sel: RES_NONE, out_load: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (accept && stat.lookup) begin
          idx_nxt   = '0;
          state_nxt = S_RREAD;
        end
      end
      S_RREAD: begin
        if (32'(idx_r) >= limit) begin
          cmd.res_sel = RES_MISS;
          state_nxt   = S_FIN;
        end else begin
          cmd.op    = OP_RREAD;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (stat.hit && stat.sparse) begin
          step_nxt  = '0;
          state_nxt = S_HASH;
        end else if (stat.hit) begin
          cmd.res_sel = RES_DENSE;
          state_nxt   = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RREAD;
        end
      end
      S_HASH: begin
        cmd.op       = sq.op;
        cmd.key_disp = sq.key_disp;
        cmd.acc_seed = sq.acc_seed;
        cmd.slot_sel = sq.slot_sel;
        if (step_r == SEQ_LAST) begin
          cmd.res_sel = RES_SPARSE;
          state_nxt   = S_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/ctgl_dp.sv =====
// ----------------------------------------------------------------------------
// ctgl_dp: lookup datapath
// Configuration registers, table memories, shared hash multiplier and the
// result and output registers.
// ----------------------------------------------------------------------------
module ctgl_dp #(
  parameter int MAX_RANGES   = 16,
  parameter int BUCKET_DEPTH = 256,
  parameter int VALUE_DEPTH  = 1024,
  parameter int RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_mode,
  input  logic [9:0]         in_table_index,
  input  logic [20:0]        in_codepoint,
  input  logic [20:0]        in_range_count,
  input  logic signed [15:0] in_glyph_value,
  input  logic [31:0]        in_displacement,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  ctgl_pkg::cmd_t     cmd,
  input  logic [RAW-1:0]     range_idx,
  output ctgl_pkg::stat_t    stat,
  output logic signed [15:0] out_glyph_index
);
  import ctgl_pkg::*;

  localparam int BAW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

  logic [31:0] seed_r;
  logic [8:0]  bcount_r;
  logic [10:0] scount_r;
  logic [4:0]  ranges_r;

  logic [20:0] cp_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] a_r, a_nxt;
  logic [15:0] res_r;
  logic [15:0] glyph_r;

  logic [31:0] idx32;
  logic [57:0] rng_rd;
  logic [31:0] disp_rd;
  logic [15:0] val_rd;
  logic [20:0] r_start, r_len;
  logic [15:0] r_base;
  logic [21:0] r_end;
  logic [31:0] baddr32, vaddr32;

  logic [31:0] mul_a, mul_b, t_acc;
  logic [63:0] prod;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      bcount_r <= 9'd1;
      scount_r <= 11'd1;
      ranges_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:   seed_r   <= cfg_data;
        REG_BUCKET: bcount_r <= cfg_data[8:0];
        REG_SLOT:   scount_r <= cfg_data[10:0];
        REG_RANGES: ranges_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // table memories, writes taken at item transfer
  assign idx32 = {22'd0, in_table_index};

  ctgl_ram #(.WIDTH(58), .DEPTH(MAX_RANGES)) u_rng (
    .clk(clk),
    .we(cmd.load && in_mode == MODE_RANGE && idx32 < 32'(MAX_RANGES)),
    .waddr(idx32[RAW-1:0]),
    .wdata({in_codepoint, in_range_count, in_glyph_value}),
    .re(cmd.op == OP_RREAD),
    .raddr(range_idx),
    .rdata_r(rng_rd)
  );

  ctgl_ram #(.WIDTH(32), .DEPTH(BUCKET_DEPTH)) u_disp (
    .clk(clk),
    .we(cmd.load && in_mode == MODE_DISP && idx32 < 32'(BUCKET_DEPTH)),
    .waddr(idx32[BAW-1:0]),
    .wdata(in_displacement),
    .re(cmd.op == OP_DREAD),
    .raddr(baddr32[BAW-1:0]),
    .rdata_r(disp_rd)
  );

  ctgl_ram #(.WIDTH(16), .DEPTH(VALUE_DEPTH)) u_val (
    .clk(clk),
    .we(cmd.load && in_mode == MODE_VALUE && idx32 < 32'(VALUE_DEPTH)),
    .waddr(idx32[VAW-1:0]),
    .wdata(in_glyph_value),
    .re(cmd.op == OP_VREAD),
    .raddr(vaddr32[VAW-1:0]),
    .rdata_r(val_rd)
  );

  // bucket and slot indexes saturate at the last table entry
  assign baddr32 = (h_r >= 32'(BUCKET_DEPTH)) ? 32'(BUCKET_DEPTH - 1) : h_r;
  assign vaddr32 = (h_r >= 32'(VALUE_DEPTH)) ? 32'(VALUE_DEPTH - 1) : h_r;

  // range match status
  assign {r_start, r_len, r_base} = rng_rd;
  assign r_end       = {1'b0, r_start} + {1'b0, r_len};
  assign stat.lookup = (in_mode == MODE_LOOKUP);
  assign stat.hit    = (cp_r >= r_start) && ({1'b0, cp_r} < r_end);
  assign stat.sparse = r_base[15];
  assign stat.ranges = ranges_r;

  // shared multiplier operand selection
  always_comb begin
    mul_a = {h_r[16:0], h_r[31:17]};
    mul_b = HC2;
    case (cmd.op)
      OP_K1: begin
        mul_a = cmd.key_disp ? disp_rd : {11'd0, cp_r};
        mul_b = HC1;
      end
      OP_M1: begin
        mul_a = h_r ^ {16'd0, h_r[31:16]};
        mul_b = HC4;
      end
      OP_M2: begin
        mul_a = h_r ^ {13'd0, h_r[31:13]};
        mul_b = HC5;
      end
      OP_MH: begin
        mul_a = h_r ^ {16'd0, h_r[31:16]};
        mul_b = cmd.slot_sel ? {21'd0, scount_r} : {23'd0, bcount_r};
      end
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign t_acc = (cmd.acc_seed ? seed_r : a_r) ^ h_r;

  // hash working registers
  always_comb begin
    h_nxt = h_r;
    a_nxt = a_r;
    case (cmd.op)
      OP_K1, OP_K2, OP_M1, OP_M2: h_nxt = prod[31:0];
      OP_MH: h_nxt = prod[63:32];
      OP_ACC: begin
        h_nxt = {t_acc[18:0], t_acc[31:19]} + {t_acc[16:0], t_acc[31:19], 2'b00}
                + HC3;
        a_nxt = h_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cp_r <= in_codepoint;
    end
    h_r <= h_nxt;
    a_r <= a_nxt;
    case (cmd.res_sel)
      RES_MISS:   res_r <= 16'hffff;
      RES_DENSE:  res_r <= r_base + cp_r[15:0] - r_start[15:0];
      RES_SPARSE: res_r <= val_rd;
      default: ;
    endcase
    if (cmd.out_load) begin
      glyph_r <= res_r;
    end
  end

  assign out_glyph_index = glyph_r;

endmodule

// ===== hdl/codepoint_to_glyph_lookup.sv =====
// ----------------------------------------------------------------------------
// codepoint_to_glyph_lookup: codepoint to glyph index mapper
// Range table scan with dense ranges and a two-level perfect hash for
// sparse ranges; write items load the range, displacement and value tables.
//
//   channel  handshake           payload
//   in_      in_valid/in_stall   mode, table_index, codepoint, range_count,
//                                glyph_value, displacement
//   out_     out_valid/out_stall glyph_index
//   cfg_     cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// A write item is taken without stalling the input. A lookup reads and checks
// each range in turn; a sparse range adds the hash steps, run in order on the
// single shared multiplier, and the two registered table reads (displacement
// and value). A miss ends once the scan reaches the clamped range count.
// Reset clears control and configuration only; tables need no clearing.
// in_stall is high for every cycle of a lookup after its transfer. A result
// waits in the output register while out_stall is high; the next item is
// still taken, and a lookup then waits in its last cycle until the output
// register frees.
// ----------------------------------------------------------------------------
module codepoint_to_glyph_lookup #(
  parameter int MAX_RANGES   = 16,
  parameter int BUCKET_DEPTH = 256,
  parameter int VALUE_DEPTH  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [9:0]         in_table_index,
  input  logic [20:0]        in_codepoint,
  input  logic [20:0]        in_range_count,
  input  logic signed [15:0] in_glyph_value,
  input  logic [31:0]        in_displacement,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_glyph_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ctgl_pkg::*;

  localparam int RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  cmd_t           cmd;
  stat_t          stat;
  logic [RAW-1:0] range_idx;

  assign cfg_ready = 1'b1;

  ctgl_ctrl #(.MAX_RANGES(MAX_RANGES)) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat(stat),
    .cmd(cmd),
    .range_idx(range_idx)
  );

  ctgl_dp #(
    .MAX_RANGES(MAX_RANGES),
    .BUCKET_DEPTH(BUCKET_DEPTH),
    .VALUE_DEPTH(VALUE_DEPTH)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_mode(in_mode),
    .in_table_index(in_table_index),
    .in_codepoint(in_codepoint),
    .in_range_count(in_range_count),
    .in_glyph_value(in_glyph_value),
    .in_displacement(in_displacement),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .range_idx(range_idx),
    .stat(stat),
    .out_glyph_index(out_glyph_index)
  );

endmodule

// ===== test/tb_codepoint_to_glyph_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_codepoint_to_glyph_lookup: self-checking bench for the glyph lookup
// Fills every table, runs directed corner items and then random phases
// under several register settings. A scoreboard mirrors the tables and the
// two-level hash and checks each glyph in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_codepoint_to_glyph_lookup;
  import ctgl_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RANGE_SLOTS = 16;
  localparam int NUM_BUCKETS = 256;
  localparam int NUM_VALUES = 1024;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 65;

  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  index;
    logic [20:0] codepoint;
    logic [20:0] count;
    logic [15:0] glyph;
    logic [31:0] disp;
  } glyph_item_t;

  // mirror of the block: tables, registers and pending glyphs
  class glyph_scoreboard;
    logic [31:0] seed;
    logic [8:0]  buckets;
    logic [10:0] slots;
    logic [4:0]  nranges;
    logic [20:0] rstart[RANGE_SLOTS];
    logic [20:0] rlen[RANGE_SLOTS];
    logic [15:0] rbase[RANGE_SLOTS];
    logic [31:0] disp_tbl[NUM_BUCKETS];
    logic [15:0] value_tbl[NUM_VALUES];
    logic [15:0] pending_glyphs[$];
    int errors;

    function new();
      seed = '0;
      buckets = 9'd1;
      slots = 11'd1;
      nranges = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_SEED:   seed = v;
        REG_BUCKET: buckets = v[8:0];
        REG_SLOT:   slots = v[10:0];
        REG_RANGES: nranges = v[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function logic [31:0] mix_round(logic [31:0] key, logic [31:0] acc);
      key = key * HC1;
      key = rotl(key, 15);
      key = key * HC2;
      acc = rotl(acc ^ key, 13);
      return acc * 32'd5 + HC3;
    endfunction

    function logic [31:0] finalize(logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * HC4;
      v = v ^ (v >> 13);
      v = v * HC5;
      return v ^ (v >> 16);
    endfunction

    function logic [31:0] mul_high(logic [31:0] h, logic [31:0] n);
      logic [63:0] p;
      p = {32'd0, h} * {32'd0, n};
      return p[63:32];
    endfunction

    function logic [15:0] sparse_glyph(logic [20:0] cp);
      logic [31:0] b;
      logic [31:0] s;
      b = mul_high(finalize(mix_round({11'd0, cp}, seed)), {23'd0, buckets});
      if (b >= NUM_BUCKETS) b = NUM_BUCKETS - 1;
      s = mul_high(finalize(mix_round({11'd0, cp}, mix_round(disp_tbl[b[7:0]], seed))),
                   {21'd0, slots});
      if (s >= NUM_VALUES) s = NUM_VALUES - 1;
      return value_tbl[s[9:0]];
    endfunction

    // applies a write, or predicts the glyph of a lookup
    function void note_item(glyph_item_t it);
      int n;
      logic [15:0] res;
      logic [31:0] lim;
      case (it.mode)
        MODE_RANGE: if (it.index < RANGE_SLOTS) begin
          rstart[it.index[3:0]] = it.codepoint;
          rlen[it.index[3:0]] = it.count;
          rbase[it.index[3:0]] = it.glyph;
        end
        MODE_DISP: if (it.index < NUM_BUCKETS) disp_tbl[it.index[7:0]] = it.disp;
        MODE_VALUE: value_tbl[it.index] = it.glyph;
        default: begin
          res = 16'hffff;
          n = (nranges > RANGE_SLOTS) ? RANGE_SLOTS : nranges;
          for (int i = 0; i < n; i++) begin
            lim = {11'd0, rstart[i]} + {11'd0, rlen[i]};
            if (it.codepoint >= rstart[i] && {11'd0, it.codepoint} < lim) begin
              if (rbase[i][15]) res = sparse_glyph(it.codepoint);
              else res = rbase[i] + 16'(it.codepoint - rstart[i]);
              break;
            end
          end
          pending_glyphs.push_back(res);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_glyph(logic [15:0] got);
      logic [15:0] want;
      if (pending_glyphs.size() == 0) begin
        report($sformatf("glyph %h with no lookup pending", got));
      end else begin
        want = pending_glyphs.pop_front();
        if (got !== want) report($sformatf("glyph_index %h, want %h", got, want));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic [9:0]         in_table_index;
  logic [20:0]        in_codepoint;
  logic [20:0]        in_range_count;
  logic signed [15:0] in_glyph_value;
  logic [31:0]        in_displacement;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_glyph_index;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  glyph_scoreboard sb = new();
  bit gaps_on;
  bit stalls_on;
  bit hold_req;
  int quiet_cycles;

  codepoint_to_glyph_lookup u_top (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // gap length: mostly short, a few long
  function int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // receiver: random stalls plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= stalls_on && ($urandom_range(0, 2) == 0);
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  // result check, sampled away from the active edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_glyph(out_glyph_index);
  end

  // watchdog on cycles without any transfer
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[codepoint_to_glyph_lookup] ERROR");
      $finish;
    end
  end

  task send_item(glyph_item_t it);
    in_mode <= it.mode;
    in_table_index <= it.index;
    in_codepoint <= it.codepoint;
    in_range_count <= it.count;
    in_glyph_value <= it.glyph;
    in_displacement <= it.disp;
    in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.note_item(it);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, let all glyphs arrive, then let writes settle
  task drain();
    in_valid <= 1'b0;
    while (sb.pending_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function glyph_item_t make_item(logic [1:0] mode, logic [9:0] idx, logic [20:0] cp,
                                  logic [20:0] cnt, logic [15:0] gv, logic [31:0] d);
    glyph_item_t it;
    it.mode = mode;
    it.index = idx;
    it.codepoint = cp;
    it.count = cnt;
    it.glyph = gv;
    it.disp = d;
    return it;
  endfunction

  // random item: mostly lookups aimed into the range table
  function glyph_item_t rand_item();
    glyph_item_t it;
    int r;
    int j;
    it = make_item(MODE_LOOKUP, 10'($urandom), 21'($urandom), 21'($urandom),
                   16'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 60) begin
      j = $urandom_range(0, RANGE_SLOTS - 1);
      if ($urandom_range(0, 3) != 0 && sb.rlen[j] != 0)
        it.codepoint = sb.rstart[j] + 21'($urandom_range(0, sb.rlen[j] - 1));
    end else if (r < 72) begin
      it.mode = MODE_RANGE;
      if ($urandom_range(0, 7) != 0) begin
        it.index = 10'($urandom_range(0, RANGE_SLOTS - 1));
        it.codepoint = 21'($urandom_range(0, 21'h10ffff));
        it.count = 21'($urandom_range(1, 8192));
      end
    end else if (r < 84) begin
      it.mode = MODE_DISP;
      if ($urandom_range(0, 7) != 0) it.index = 10'($urandom_range(0, NUM_BUCKETS - 1));
    end else begin
      it.mode = MODE_VALUE;
    end
    return it;
  endfunction

  logic [31:0] phase_seed[6];
  logic [31:0] phase_buckets[6];
  logic [31:0] phase_slots[6];
  logic [31:0] phase_ranges[6];

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOOKUP;
    in_table_index = '0;
    in_codepoint = '0;
    in_range_count = '0;
    in_glyph_value = '0;
    in_displacement = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SEED;
    cfg_data = '0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill every table entry so no lookup reads an unwritten one
    for (int i = 0; i < RANGE_SLOTS; i++)
      send_item(make_item(MODE_RANGE, 10'(i), 21'($urandom_range(0, 21'h10ffff)),
                          21'($urandom_range(1, 4096)), 16'($urandom), '0));
    for (int i = 0; i < NUM_BUCKETS; i++)
      send_item(make_item(MODE_DISP, 10'(i), '0, '0, '0, $urandom));
    for (int i = 0; i < NUM_VALUES; i++)
      send_item(make_item(MODE_VALUE, 10'(i), '0, '0, 16'($urandom), '0));

    // no ranges scanned yet: miss
    send_item(make_item(MODE_LOOKUP, '0, 21'h20, '0, '0, '0));
    drain();
    write_reg(REG_SEED, 32'h9747b28c);
    write_reg(REG_BUCKET, 32'd256);
    write_reg(REG_SLOT, 32'd1024);
    write_reg(REG_RANGES, 32'd16);
    write_reg(REG_UNUSED, 32'hffffffff);

    // directed corners: dense wrap, widest range, sparse, empty range,
    // ignored writes, extreme codepoints
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_item(make_item(MODE_RANGE, 10'd0, 21'h20, 21'h60, 16'h7ff0, '0));
    send_item(make_item(MODE_RANGE, 10'd1, 21'h10000, 21'h100000, 16'h7fff, '0));
    send_item(make_item(MODE_RANGE, 10'd2, 21'h110000, 21'h110000, 16'h8000, '0));
    send_item(make_item(MODE_RANGE, 10'd3, 21'h3000, 21'd0, 16'h0000, '0));
    send_item(make_item(MODE_RANGE, 10'd1023, 21'h0, 21'h1fffff, 16'h0001, '0));
    send_item(make_item(MODE_DISP, 10'd1023, '0, '0, '0, 32'hffffffff));
    send_item(make_item(MODE_VALUE, 10'd1023, '0, '0, 16'h8000, '0));
    send_item(make_item(MODE_VALUE, 10'd0, '0, '0, 16'h7fff, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h20, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h7f, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h10ffff, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h1fffff, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h110000, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h3000, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h0, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, '0, 21'h1ffffe, '0, '0, '0));
    drain();

    // settings: defaults, full sizes, zero counts, saturation, random
    phase_seed = '{$urandom, $urandom, 32'h0, 32'hffffffff, $urandom, $urandom};
    phase_buckets = '{32'd1, 32'd256, 32'd0, 32'd511, $urandom_range(1, 256), 32'd17};
    phase_slots = '{32'd1, 32'd1024, 32'd0, 32'd2047, $urandom_range(1, 1024), 32'd300};
    phase_ranges = '{32'd16, 32'd16, 32'd5, 32'd31, $urandom_range(0, 16), 32'd16};

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SEED, phase_seed[p]);
      write_reg(REG_BUCKET, phase_buckets[p]);
      write_reg(REG_SLOT, phase_slots[p]);
      write_reg(REG_RANGES, phase_ranges[p]);
      gaps_on = (p != 1);
      stalls_on = (p != 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 20) hold_req = 1'b1;
        send_item(rand_item());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("[codepoint_to_glyph_lookup] OK");
    end else begin
      $display("[codepoint_to_glyph_lookup] ERROR");
    end
    $finish;
  end

endmodule

// ===== codepoint_to_glyph_lookup.f =====
hdl/ctgl_pkg.sv
hdl/ctgl_ram.sv
hdl/ctgl_ctrl.sv
hdl/ctgl_dp.sv
hdl/codepoint_to_glyph_lookup.sv
test/tb_codepoint_to_glyph_lookup.sv
